FILE: hw/rtl/vcs_pkg.sv
// ============================================================================
// vcs_pkg
// Shared types and constants of the velocity command smoother.
// ============================================================================
package vcs_pkg;

    localparam int VEL_BITS   = 16;
    localparam int STAMP_BITS = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_CAPACITY = 2'd0,
        REG_EXPIRY_TICKS  = 2'd1,
        REG_SILENCE_TICKS = 2'd2,
        REG_STEP_LIMIT    = 2'd3
    } t_cfg_reg;

    localparam logic [4:0]  CAP_RESET     = 5'd12;
    localparam logic [15:0] EXPIRY_RESET  = 16'd120;
    localparam logic [15:0] SILENCE_RESET = 16'd3;
    localparam logic [14:0] STEP_RESET    = 15'd1229;

    typedef struct packed {
        logic [STAMP_BITS-1:0]      tick_time;
        logic                       new_command;
        logic signed [VEL_BITS-1:0] cmd_vx;
        logic signed [VEL_BITS-1:0] cmd_vy;
        logic signed [VEL_BITS-1:0] cmd_wz;
    } t_in_item;

    typedef struct packed {
        logic signed [VEL_BITS-1:0] out_vx;
        logic signed [VEL_BITS-1:0] out_vy;
        logic signed [VEL_BITS-1:0] out_wz;
    } t_out_item;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DROP_RD,
        S_DROP_CHK,
        S_REFILL,
        S_PUSH,
        S_STAMP_RD,
        S_STAMP_CHK,
        S_SUM,
        S_DEV,
        S_DIV_GO,
        S_DIV_WAIT,
        S_FINISH
    } t_state;

endpackage

FILE: hw/rtl/vcs_ram.sv
// ============================================================================
// vcs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module vcs_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

FILE: hw/rtl/vcs_div.sv
// ============================================================================
// vcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ============================================================================
module vcs_div #(
    parameter int NW = 22,
    parameter int DW = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int KW = $clog2(NW + 1);

    logic [DW:0]   r_rem;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_den;
    logic [KW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [DW:0]   rem_sh;

    assign rem_sh = {r_rem[DW-1:0], r_q[NW-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= KW'(NW);
                r_rem  <= '0;
                r_q    <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (rem_sh >= {1'b0, r_den}) begin
                    r_rem <= rem_sh - {1'b0, r_den};
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == KW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

FILE: hw/rtl/velocity_command_smoother.sv
// ============================================================================
// velocity_command_smoother
// Trimmed-mean smoother with step clamp for planar velocity commands.
// ============================================================================
// One input transfer per control tick. The ring of timestamped commands lives
// in one RAM (registered read), walked by a sequencer: expired entries are
// dropped oldest first (a read state and a check state per entry), pushes and
// zero refills write one entry at a time, then two pipelined passes over the
// ring form the sum and find the outlier of each axis, and three divider
// lanes give the rounded mean; a ring of one entry skips the second pass and
// the division. A tick that neither emits nor feeds zeros is taken in S_IDLE
// and does not start the sequencer. After reset and after every ring_capacity
// write the RAM is cleared entry by entry, during which no input is taken
// (configuration still is). The result register lets a new tick enter while
// a result waits to be taken.
// ============================================================================
module velocity_command_smoother #(
    parameter int RING_DEPTH = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  vcs_pkg::t_in_item               i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output vcs_pkg::t_out_item              o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    localparam int VB  = vcs_pkg::VEL_BITS;
    localparam int TB  = vcs_pkg::STAMP_BITS;
    localparam int AW  = $clog2(RING_DEPTH);
    localparam int CW  = $clog2(RING_DEPTH + 1);
    localparam int SW  = VB + CW;          // axis sum
    localparam int DVW = SW + 2;           // deviation |sum - n*x|
    localparam int NW  = SW + 1;           // divider numerator
    localparam int DW  = CW + 1;           // divider denominator
    localparam int EW  = VB + 3;           // clamp arithmetic
    localparam int RW  = 3 * VB + TB;      // RAM word: vx, vy, wz, stamp

    // ---------------- registers ----------------
    vcs_pkg::t_state r_state, n_state;

    logic [4:0]       r_cap;
    logic [15:0]      r_expiry, r_silence;
    logic [14:0]      r_step;
    logic [AW-1:0]    r_head, n_head;
    logic [CW-1:0]    r_fill, n_fill;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CW-1:0]    r_pcnt, n_pcnt;
    logic [TB-1:0]    r_now, n_now;
    logic [TB-1:0]    r_last_emit, n_last_emit;
    logic             r_silent, n_silent;
    logic             r_emit, n_emit;
    logic             r_clamp, n_clamp;
    logic             r_have, n_have;
    logic             r_rd_vld, n_rd_vld;
    logic             r_first, n_first;
    logic             r_out_valid, n_out_valid;
    logic signed [VB-1:0]  r_last_cmd [3], n_last_cmd [3];
    logic signed [VB-1:0]  r_prev [3], n_prev [3];
    logic signed [VB-1:0]  r_out [3], n_out [3];
    logic signed [VB-1:0]  r_far [3], n_far [3];
    logic signed [SW-1:0]  r_sum [3], n_sum [3];
    logic [DVW-1:0]        r_best [3], n_best [3];
    logic signed [VB:0]    r_mean [3], n_mean [3];
    logic                  r_neg [3], n_neg [3];

    // ---------------- RAM ----------------
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;

    vcs_ram #(.WIDTH(RW), .DEPTH(RING_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ---------------- divider lanes ----------------
    logic          div_start;
    logic [NW-1:0] div_num [3];
    logic [DW-1:0] div_den;
    logic          div_done [3];
    logic [NW-1:0] div_quot [3];

    for (genvar a = 0; a < 3; a++) begin : g_div
        vcs_div #(.NW(NW), .DW(DW)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (div_start),
            .i_num   (div_num[a]),
            .i_den   (div_den),
            .o_done  (div_done[a]),
            .o_quot  (div_quot[a])
        );
    end

    // ---------------- helpers ----------------
    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] h, input logic [CW-1:0] i);
        logic [AW+1:0] s;
        s = (AW+2)'(h) + (AW+2)'(i);
        if (s >= (AW+2)'(RING_DEPTH)) begin
            s = s - (AW+2)'(RING_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    logic [CW-1:0]  cap_eff;
    logic           in_fire, cfg_fire, cap_write;
    logic [TB-1:0]  rd_stamp;
    logic signed [VB-1:0] rd_x [3];
    logic           rd_expired;
    logic           cmd_zero;
    logic           scan_done;
    logic [CW+7:0]  div3_prod;
    logic [CW-1:0]  fill_div3;
    logic [AW-1:0]  head_dec;
    logic [CW-1:0]  fill_inc;
    logic           out_blocked;
    logic           silence_over;
    logic           last_zero;

    always_comb begin
        if (r_cap < 5'd2) begin
            cap_eff = CW'(2);
        end else if (32'(r_cap) > RING_DEPTH) begin
            cap_eff = CW'(RING_DEPTH);
        end else begin
            cap_eff = CW'(r_cap);
        end
    end

    assign o_in_ready  = (r_state == vcs_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_in_valid && o_in_ready;
    assign cfg_fire    = i_cfg_valid;
    assign cap_write   = cfg_fire && (i_cfg_index == vcs_pkg::REG_RING_CAPACITY);

    assign rd_stamp   = ram_rdata[TB-1:0];
    assign rd_x[0]    = ram_rdata[TB+2*VB +: VB];
    assign rd_x[1]    = ram_rdata[TB+VB +: VB];
    assign rd_x[2]    = ram_rdata[TB +: VB];
    assign rd_expired = (r_now - rd_stamp) >= {16'd0, r_expiry};

    assign last_zero  = (r_last_cmd[0] == '0) && (r_last_cmd[1] == '0) && (r_last_cmd[2] == '0);
    assign cmd_zero   = r_silent || last_zero;
    assign scan_done  = (r_cnt == r_fill) && !r_rd_vld;

    // floor(fill/3) by reciprocal, exact for fill below 256
    assign div3_prod  = (CW+8)'(r_fill) * (CW+8)'(171);
    assign fill_div3  = CW'(div3_prod >> 9);

    assign head_dec   = (r_head == '0) ? AW'(RING_DEPTH - 1) : r_head - 1'b1;
    assign fill_inc   = (r_fill < cap_eff) ? r_fill + 1'b1 : r_fill;
    assign out_blocked  = r_emit && r_out_valid && !i_out_ready;
    assign silence_over = (i_in.tick_time - r_last_emit) > {16'd0, r_silence};

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vcs_pkg::S_CLEAR: begin
                if (r_cnt == CW'(RING_DEPTH - 1)) n_state = vcs_pkg::S_IDLE;
            end
            vcs_pkg::S_IDLE: begin
                if (in_fire && (i_in.new_command || silence_over || last_zero)) begin
                    n_state = vcs_pkg::S_DROP_RD;
                end
            end
            vcs_pkg::S_DROP_RD: begin
                n_state = (r_fill == '0) ? vcs_pkg::S_REFILL : vcs_pkg::S_DROP_CHK;
            end
            vcs_pkg::S_DROP_CHK: begin
                n_state = rd_expired ? vcs_pkg::S_DROP_RD : vcs_pkg::S_PUSH;
            end
            vcs_pkg::S_REFILL: begin
                if (r_pcnt == '0) n_state = vcs_pkg::S_PUSH;
            end
            vcs_pkg::S_PUSH: begin
                if (r_pcnt == '0) n_state = vcs_pkg::S_STAMP_RD;
            end
            vcs_pkg::S_STAMP_RD: begin
                n_state = (r_have && r_fill > CW'(2)) ? vcs_pkg::S_STAMP_CHK
                                                       : vcs_pkg::S_SUM;
            end
            vcs_pkg::S_STAMP_CHK: n_state = vcs_pkg::S_SUM;
            vcs_pkg::S_SUM: begin
                if (scan_done) begin
                    n_state = (r_fill == CW'(1)) ? vcs_pkg::S_FINISH : vcs_pkg::S_DEV;
                end
            end
            vcs_pkg::S_DEV: begin
                if (scan_done) n_state = vcs_pkg::S_DIV_GO;
            end
            vcs_pkg::S_DIV_GO:   n_state = vcs_pkg::S_DIV_WAIT;
            vcs_pkg::S_DIV_WAIT: begin
                if (div_done[0]) n_state = vcs_pkg::S_FINISH;
            end
            vcs_pkg::S_FINISH: begin
                if (!out_blocked) n_state = vcs_pkg::S_IDLE;
            end
            default: n_state = vcs_pkg::S_CLEAR;
        endcase
        // a capacity write restarts the clearing pass
        if (cap_write) n_state = vcs_pkg::S_CLEAR;
    end

    // ---------------- datapath ----------------
    logic signed [DVW-1:0] dv_prod, dv_diff;
    logic [DVW-1:0]        dv_abs;
    logic signed [SW:0]    md_num;
    logic [SW:0]           md_mag;
    logic signed [EW-1:0]  cl_r, cl_p, cl_d, cl_lim;

    always_comb begin
        n_head      = r_head;
        n_fill      = r_fill;
        n_cnt       = r_cnt;
        n_pcnt      = r_pcnt;
        n_now       = r_now;
        n_last_emit = r_last_emit;
        n_silent    = r_silent;
        n_emit      = r_emit;
        n_clamp     = r_clamp;
        n_have      = r_have;
        n_rd_vld    = 1'b0;
        n_first     = r_first;
        n_out_valid = r_out_valid && !i_out_ready;
        n_last_cmd  = r_last_cmd;
        n_prev      = r_prev;
        n_out       = r_out;
        n_far       = r_far;
        n_sum       = r_sum;
        n_best      = r_best;
        n_mean      = r_mean;
        n_neg       = r_neg;
        ram_we      = 1'b0;
        ram_waddr   = head_dec;
        ram_wdata   = {r_silent ? (3*VB)'(0) : {r_last_cmd[0], r_last_cmd[1], r_last_cmd[2]},
                       r_now};
        ram_raddr   = f_slot(r_head, r_cnt);
        div_start   = 1'b0;
        div_den     = {r_fill - 1'b1, 1'b0};
        dv_prod     = '0;
        dv_diff     = '0;
        dv_abs      = '0;
        md_num      = '0;
        md_mag      = '0;
        cl_r        = '0;
        cl_p        = '0;
        cl_d        = '0;
        cl_lim      = EW'(r_step);
        for (int a = 0; a < 3; a++) begin
            div_num[a] = '0;
        end

        unique case (r_state)
            vcs_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt[AW-1:0];
                ram_wdata = '0;
                n_cnt     = r_cnt + 1'b1;
                n_head    = '0;
                n_fill    = cap_eff;
            end
            vcs_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_now = i_in.tick_time;
                    if (i_in.new_command) begin
                        n_last_cmd[0] = i_in.cmd_vx;
                        n_last_cmd[1] = i_in.cmd_vy;
                        n_last_cmd[2] = i_in.cmd_wz;
                        n_last_emit   = i_in.tick_time;
                        n_silent      = 1'b0;
                        n_emit        = 1'b1;
                    end else if (silence_over) begin
                        n_silent = 1'b1;
                        n_emit   = 1'b0;
                    end else begin
                        n_silent = 1'b0;
                        n_emit   = 1'b1;
                    end
                end
            end
            vcs_pkg::S_DROP_RD: begin
                // read the oldest entry; empty ring means everything expired
                ram_raddr = f_slot(r_head, r_fill - 1'b1);
                if (r_fill == '0) n_pcnt = cap_eff;
            end
            vcs_pkg::S_DROP_CHK: begin
                if (rd_expired) begin
                    n_fill = r_fill - 1'b1;
                end else begin
                    n_pcnt = cmd_zero ? fill_div3 : CW'(1);
                end
            end
            vcs_pkg::S_REFILL: begin
                if (r_pcnt == '0) begin
                    n_pcnt = CW'(1);
                end else begin
                    ram_we    = 1'b1;
                    ram_wdata = {(3*VB)'(0), r_now};
                    n_head    = head_dec;
                    n_fill    = fill_inc;
                    n_pcnt    = r_pcnt - 1'b1;
                end
            end
            vcs_pkg::S_PUSH: begin
                if (r_pcnt != '0) begin
                    ram_we = 1'b1;
                    n_head = head_dec;
                    n_fill = fill_inc;
                    n_pcnt = r_pcnt - 1'b1;
                end
            end
            vcs_pkg::S_STAMP_RD: begin
                ram_raddr = f_slot(r_head, CW'(2));
                n_clamp   = 1'b0;
                n_cnt     = '0;
                for (int a = 0; a < 3; a++) n_sum[a] = '0;
            end
            vcs_pkg::S_STAMP_CHK: begin
                n_clamp = (rd_stamp != r_now);
            end
            vcs_pkg::S_SUM: begin
                if (r_cnt != r_fill) begin
                    n_cnt    = r_cnt + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    for (int a = 0; a < 3; a++) n_sum[a] = r_sum[a] + SW'(rd_x[a]);
                end
                if (scan_done) begin
                    n_cnt   = '0;
                    n_first = 1'b1;
                    for (int a = 0; a < 3; a++) n_mean[a] = (VB+1)'(r_sum[a]);
                end
            end
            vcs_pkg::S_DEV: begin
                if (r_cnt != r_fill) begin
                    n_cnt    = r_cnt + 1'b1;
                    n_rd_vld = 1'b1;
                end
                if (r_rd_vld) begin
                    n_first = 1'b0;
                    for (int a = 0; a < 3; a++) begin
                        dv_prod = DVW'($signed({1'b0, r_fill})) * DVW'(rd_x[a]);
                        dv_diff = DVW'(r_sum[a]) - dv_prod;
                        dv_abs  = dv_diff[DVW-1] ? DVW'(-dv_diff) : DVW'(dv_diff);
                        // strict compare keeps the newest sample on a tie
                        if (r_first || dv_abs > r_best[a]) begin
                            n_best[a] = dv_abs;
                            n_far[a]  = rd_x[a];
                        end
                    end
                end
            end
            vcs_pkg::S_DIV_GO: begin
                div_start = 1'b1;
                for (int a = 0; a < 3; a++) begin
                    md_num     = (SW+1)'(r_sum[a]) - (SW+1)'(r_far[a]);
                    md_mag     = md_num[SW] ? (SW+1)'(-md_num) : (SW+1)'(md_num);
                    n_neg[a]   = md_num[SW];
                    div_num[a] = NW'({md_mag, 1'b0}) + NW'(r_fill - 1'b1);
                end
            end
            vcs_pkg::S_DIV_WAIT: begin
                if (div_done[0]) begin
                    for (int a = 0; a < 3; a++) begin
                        n_mean[a] = r_neg[a] ? -$signed((VB+1)'(div_quot[a]))
                                             : $signed((VB+1)'(div_quot[a]));
                    end
                end
            end
            vcs_pkg::S_FINISH: begin
                if (!out_blocked) begin
                    for (int a = 0; a < 3; a++) begin
                        cl_r = EW'(r_mean[a]);
                        cl_p = EW'(r_prev[a]);
                        cl_d = cl_r - cl_p;
                        if (r_clamp && cl_d > cl_lim) begin
                            cl_r = cl_p + cl_lim;
                        end else if (r_clamp && cl_d < -cl_lim) begin
                            cl_r = cl_p - cl_lim;
                        end
                        if (cl_r > EW'(2**(VB-1) - 1)) begin
                            cl_r = EW'(2**(VB-1) - 1);
                        end else if (cl_r < -EW'(2**(VB-1))) begin
                            cl_r = -EW'(2**(VB-1));
                        end
                        n_prev[a] = VB'(cl_r);
                        if (r_emit) n_out[a] = VB'(cl_r);
                    end
                    n_have = 1'b1;
                    if (r_emit) n_out_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (cap_write) begin
            n_cnt = '0;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vcs_pkg::S_CLEAR;
            r_cap       <= vcs_pkg::CAP_RESET;
            r_expiry    <= vcs_pkg::EXPIRY_RESET;
            r_silence   <= vcs_pkg::SILENCE_RESET;
            r_step      <= vcs_pkg::STEP_RESET;
            r_cnt       <= '0;
            r_head      <= '0;
            r_fill      <= '0;
            r_pcnt      <= '0;
            r_last_emit <= '0;
            r_have      <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_silent    <= 1'b0;
            r_emit      <= 1'b0;
            r_clamp     <= 1'b0;
            r_first     <= 1'b0;
            for (int a = 0; a < 3; a++) begin
                r_last_cmd[a] <= '0;
                r_prev[a]     <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_head      <= n_head;
            r_fill      <= n_fill;
            r_pcnt      <= n_pcnt;
            r_last_emit <= n_last_emit;
            r_have      <= n_have;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            r_silent    <= n_silent;
            r_emit      <= n_emit;
            r_clamp     <= n_clamp;
            r_first     <= n_first;
            r_last_cmd  <= n_last_cmd;
            r_prev      <= n_prev;
            if (cfg_fire) begin
                unique case (vcs_pkg::t_cfg_reg'(i_cfg_index))
                    vcs_pkg::REG_RING_CAPACITY: r_cap     <= i_cfg_data[4:0];
                    vcs_pkg::REG_EXPIRY_TICKS:  r_expiry  <= i_cfg_data;
                    vcs_pkg::REG_SILENCE_TICKS: r_silence <= i_cfg_data;
                    vcs_pkg::REG_STEP_LIMIT:    r_step    <= i_cfg_data[14:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_now  <= n_now;
        r_out  <= n_out;
        r_far  <= n_far;
        r_sum  <= n_sum;
        r_best <= n_best;
        r_mean <= n_mean;
        r_neg  <= n_neg;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out.out_vx  = r_out[0];
    assign o_out.out_vy  = r_out[1];
    assign o_out.out_wz  = r_out[2];
endmodule

FILE: hw/rtl/vcs_checker.sv
// ============================================================================
// vcs_checker
// Port-level checks of the velocity command smoother.
// ============================================================================
module vcs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input vcs_pkg::t_in_item  i_in,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input vcs_pkg::t_out_item o_out
);
    // no result right after reset
    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // ring clear runs after reset, so no input is taken
    a_rst_in: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("input ready during clear");

    // one tick in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready || !i_in.new_command || $past(!i_in.new_command))
        else $error("ready held after command transfer");

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out)))
        else $error("result changed while stalled");
endmodule

bind velocity_command_smoother vcs_checker u_vcs_checker (.*);

FILE: tb/velocity_command_smoother_tb.sv
// ============================================================================
// velocity_command_smoother_tb
// Self-checking bench for the velocity command smoother.
// ============================================================================
// A queue of pending ticks feeds a valid/ready driver; a monitor predicts each
// accepted tick with a local copy of the ring, the timers and the registers,
// and compares every result transfer against the oldest prediction. Phases
// change the registers (extremes included) and the idle/stall mix.
// ============================================================================
module velocity_command_smoother_tb;

    localparam int DEPTH      = 16;
    localparam int DRAIN_WAIT = 300;       // worst tick is well under this
    localparam int MAX_CYCLES = 1500000;

    logic                                  i_clk = 1'b0;
    logic                                  i_rst_n = 1'b0;
    logic                                  i_in_valid = 1'b0;
    logic                                  o_in_ready;
    vcs_pkg::t_in_item                     i_in = '0;
    logic                                  o_out_valid;
    logic                                  i_out_ready = 1'b0;
    vcs_pkg::t_out_item                    o_out;
    logic                                  i_cfg_valid = 1'b0;
    logic                                  o_cfg_ready;
    logic [vcs_pkg::CFG_IDX_W-1:0]         i_cfg_index = '0;
    logic [vcs_pkg::CFG_DATA_W-1:0]        i_cfg_data = '0;

    velocity_command_smoother #(.RING_DEPTH(DEPTH)) uut (.*);

    // Stimulus and expectation stores
    vcs_pkg::t_in_item   tick_q[$];
    vcs_pkg::t_cfg_reg   cfg_idx_q[$];
    logic [15:0]         cfg_dat_q[$];
    vcs_pkg::t_out_item  smooth_q[$];

    int  send_idle = 0;     // percent of cycles the sender holds off
    int  recv_stall = 0;    // percent of cycles the receiver stalls
    bit  in_took, cfg_took;
    int  errors = 0;
    int  cycles = 0;
    logic [31:0] tick_now = 0;

    // ------------------------------------------------------------------------
    // Predictor state
    // ------------------------------------------------------------------------
    logic [4:0]  cap_reg;
    logic [15:0] expiry_reg, silence_reg;
    logic [14:0] step_reg;
    int          smp[DEPTH][3];
    logic [31:0] stamp[DEPTH];
    int          head, fill;
    int          prev_out[3];
    bit          have_out;
    logic [31:0] last_emit;
    int          last_cmd[3];

    function automatic int cap_eff();
        int c;
        c = cap_reg;
        if (c < 2) c = 2;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic int slot(int i);
        return (head + i) % DEPTH;
    endfunction

    function automatic void push_entry(int v0, int v1, int v2, logic [31:0] now);
        head = (head + DEPTH - 1) % DEPTH;
        smp[head][0] = v0;
        smp[head][1] = v1;
        smp[head][2] = v2;
        stamp[head] = now;
        if (fill < cap_eff()) fill++;
    endfunction

    function automatic void refill_zeros(logic [31:0] now);
        fill = 0;
        while (fill < cap_eff()) push_entry(0, 0, 0, now);
    endfunction

    function automatic void clear_ring();
        for (int i = 0; i < DEPTH; i++) begin
            stamp[i] = '0;
            for (int a = 0; a < 3; a++) smp[i][a] = 0;
        end
        head = 0;
        fill = cap_eff();
    endfunction

    function automatic bit is_stale(int i, logic [31:0] now);
        logic [31:0] age;
        age = now - stamp[slot(i)];
        return age >= {16'd0, expiry_reg};
    endfunction

    // Drop stale entries, store the command: a stop fill/3 times, once after a refill
    function automatic void store_command(int c0, int c1, int c2, logic [31:0] now);
        bit all_stale;
        int k;
        all_stale = 1'b1;
        for (int i = 0; i < fill; i++)
            if (!is_stale(i, now)) all_stale = 1'b0;
        if (all_stale) begin
            refill_zeros(now);
            push_entry(c0, c1, c2, now);
            return;
        end
        while (fill > 0 && is_stale(fill - 1, now)) fill--;
        if (fill == 0) refill_zeros(now);
        if (c0 == 0 && c1 == 0 && c2 == 0) begin
            k = fill / 3;
            for (int i = 0; i < k; i++) push_entry(0, 0, 0, now);
        end else begin
            push_entry(c0, c1, c2, now);
        end
    endfunction

    // Mean without the sample farthest from the plain mean; ties to the newest
    function automatic longint outlier_free_mean(int axis);
        longint sum, best, dev, num, d, q;
        int far;
        sum = 0;
        far = 0;
        for (int i = 0; i < fill; i++) sum += smp[slot(i)][axis];
        if (fill == 1) return sum;
        best = sum - longint'(fill) * smp[slot(0)][axis];
        if (best < 0) best = -best;
        for (int i = 1; i < fill; i++) begin
            dev = sum - longint'(fill) * smp[slot(i)][axis];
            if (dev < 0) dev = -dev;
            if (dev > best) begin
                best = dev;
                far = i;
            end
        end
        num = sum - smp[slot(far)][axis];
        d = fill - 1;
        q = (2 * (num < 0 ? -num : num) + d) / (2 * d);
        return num < 0 ? -q : q;
    endfunction

    function automatic vcs_pkg::t_out_item smooth(int c0, int c1, int c2, logic [31:0] now);
        bit clamp;
        longint r, lim;
        vcs_pkg::t_out_item res;
        int v[3];
        store_command(c0, c1, c2, now);
        clamp = have_out && fill > 2 && stamp[slot(2)] != now;
        lim = step_reg;
        for (int a = 0; a < 3; a++) begin
            r = outlier_free_mean(a);
            if (clamp) begin
                if (r - prev_out[a] > lim) r = prev_out[a] + lim;
                else if (r - prev_out[a] < -lim) r = prev_out[a] - lim;
            end
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            prev_out[a] = int'(r);
            v[a] = int'(r);
        end
        have_out = 1'b1;
        res.out_vx = v[0][15:0];
        res.out_vy = v[1][15:0];
        res.out_wz = v[2][15:0];
        return res;
    endfunction

    // One accepted tick: new command, silent zero feed, repeated stop, or nothing
    function automatic void predict_tick(vcs_pkg::t_in_item it);
        logic [31:0] since;
        since = it.tick_time - last_emit;
        if (it.new_command) begin
            last_cmd[0] = int'(it.cmd_vx);
            last_cmd[1] = int'(it.cmd_vy);
            last_cmd[2] = int'(it.cmd_wz);
            smooth_q.push_back(smooth(last_cmd[0], last_cmd[1], last_cmd[2], it.tick_time));
            last_emit = it.tick_time;
        end else if (since > {16'd0, silence_reg}) begin
            void'(smooth(0, 0, 0, it.tick_time));
        end else if (last_cmd[0] == 0 && last_cmd[1] == 0 && last_cmd[2] == 0) begin
            smooth_q.push_back(smooth(0, 0, 0, it.tick_time));
        end
    endfunction

    function automatic void predict_cfg(vcs_pkg::t_cfg_reg idx, logic [15:0] data);
        case (idx)
            vcs_pkg::REG_RING_CAPACITY: begin
                cap_reg = data[4:0];
                clear_ring();
            end
            vcs_pkg::REG_EXPIRY_TICKS:  expiry_reg = data;
            vcs_pkg::REG_SILENCE_TICKS: silence_reg = data;
            vcs_pkg::REG_STEP_LIMIT:    step_reg = data[14:0];
            default: ;
        endcase
    endfunction

    initial begin
        cap_reg = vcs_pkg::CAP_RESET;
        expiry_reg = vcs_pkg::EXPIRY_RESET;
        silence_reg = vcs_pkg::SILENCE_RESET;
        step_reg = vcs_pkg::STEP_RESET;
        clear_ring();
        have_out = 1'b0;
        last_emit = '0;
        for (int a = 0; a < 3; a++) begin
            prev_out[a] = 0;
            last_cmd[a] = 0;
        end
    end

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // Driver: payloads change at the falling edge only
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_took) begin
                if (tick_q.size() > 0 && $urandom_range(99) >= send_idle) begin
                    i_in <= tick_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (!i_cfg_valid || cfg_took) begin
                if (cfg_idx_q.size() > 0) begin
                    i_cfg_index <= cfg_idx_q.pop_front();
                    i_cfg_data <= cfg_dat_q.pop_front();
                    i_cfg_valid <= 1'b1;
                end else begin
                    i_cfg_valid <= 1'b0;
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall);
        end
        in_took = 1'b0;
        cfg_took = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: transfers are taken at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        vcs_pkg::t_out_item want;
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end else if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_took = 1'b1;
                predict_tick(i_in);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_took = 1'b1;
                predict_cfg(vcs_pkg::t_cfg_reg'(i_cfg_index), i_cfg_data);
            end
            if (o_out_valid && i_out_ready) begin
                if (smooth_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result transfer %h at cycle %0d", o_out, cycles);
                end else begin
                    want = smooth_q.pop_front();
                    if (o_out.out_vx !== want.out_vx || o_out.out_vy !== want.out_vy ||
                        o_out.out_wz !== want.out_wz) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch at cycle %0d: vx %0d/%0d vy %0d/%0d wz %0d/%0d",
                                     cycles, want.out_vx, o_out.out_vx, want.out_vy,
                                     o_out.out_vy, want.out_wz, o_out.out_wz);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic put_tick(logic [31:0] t, bit nc, int x, int y, int z);
        vcs_pkg::t_in_item it;
        it.tick_time = t;
        it.new_command = nc;
        it.cmd_vx = x[15:0];
        it.cmd_vy = y[15:0];
        it.cmd_wz = z[15:0];
        tick_q.push_back(it);
    endtask

    function automatic int pick_vel();
        int r;
        r = $urandom_range(99);
        if (r < 10) return ($urandom_range(1) ? 32767 : -32768);
        if (r < 30) return $urandom_range(0, 400) - 200;
        return int'($signed(16'($urandom)));
    endfunction

    task automatic put_random_tick();
        int r;
        r = $urandom_range(99);
        if (r < 70) tick_now += $urandom_range(0, 3);
        else if (r < 90) tick_now += $urandom_range(4, 40);
        else if (r < 97) tick_now += $urandom_range(41, 300);
        else tick_now = $urandom;
        if ($urandom_range(99) < 25)
            put_tick(tick_now, $urandom_range(99) < 60, 0, 0, 0);
        else
            put_tick(tick_now, $urandom_range(99) < 60, pick_vel(), pick_vel(), pick_vel());
    endtask

    task automatic write_reg(vcs_pkg::t_cfg_reg idx, logic [15:0] data);
        cfg_idx_q.push_back(idx);
        cfg_dat_q.push_back(data);
    endtask

    // Wait until every tick and write is taken and every result has arrived,
    // then let a tick that emits nothing finish its work
    task automatic drain();
        while (tick_q.size() > 0 || cfg_idx_q.size() > 0 || i_in_valid || i_cfg_valid ||
               smooth_q.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic run_phase(int idle, int stall, logic [4:0] cap, logic [15:0] expiry,
                             logic [15:0] silence, logic [14:0] step, int count);
        drain();
        write_reg(vcs_pkg::REG_RING_CAPACITY, {11'd0, cap});
        write_reg(vcs_pkg::REG_EXPIRY_TICKS, expiry);
        write_reg(vcs_pkg::REG_SILENCE_TICKS, silence);
        write_reg(vcs_pkg::REG_STEP_LIMIT, {1'b0, step});
        drain();
        send_idle = idle;
        recv_stall = stall;
        for (int i = 0; i < count; i++) put_random_tick();
    endtask

    initial begin
        @(posedge i_rst_n);

        // Directed ticks at reset settings, no idling
        put_tick(0, 1, 32767, -32768, 32767);           // first output, no clamp
        put_tick(0, 1, -32768, 32767, -32768);          // third stamp equals now
        put_tick(1, 0, 5, 5, 5);                        // held command: nothing
        put_tick(10, 0, 0, 0, 0);                       // silence: zeros fed quietly
        put_tick(11, 1, 0, 0, 0);                       // stop command
        put_tick(12, 0, 0, 0, 0);                       // repeated stop emits
        put_tick(13, 1, -32768, -32768, -32768);
        put_tick(14, 1, 32767, 32767, 32767);
        put_tick(200, 1, 1, -1, 0);                     // everything expired
        put_tick(250, 1, 100, 200, 300);                // nothing expired yet
        put_tick(32'hFFFF_FFFE, 1, -7, 8, -9);
        put_tick(32'hFFFF_FFFF, 1, 32767, 0, -32768);
        put_tick(0, 1, 3, 3, 3);                        // tick counter wraps
        put_tick(1, 0, 0, 0, 0);
        put_tick(2, 1, 0, 0, 0);
        put_tick(3, 0, 0, 0, 0);
        put_tick(4, 0, 0, 0, 0);
        put_tick(4, 1, 1000, -1000, 2000);
        tick_now = 4;

        // Extremes and mixed settings under each idling pattern
        run_phase(77, 0, 5'd2, 16'd1, 16'd1, 15'd0, 250);
        drain();
        // sender holds off here until every result is back
        for (int i = 0; i < 50; i++) put_random_tick();
        run_phase(0, 77, 5'd16, 16'd65535, 16'd65535, 15'd32767, 300);
        run_phase(21, 21, 5'd0, 16'd0, 16'd5, 15'd100, 250);
        run_phase(0, 0, 5'd31, 16'd20, 16'd2, 15'd500, 300);
        run_phase(21, 21, 5'd5, 16'd8, 16'd3, 15'd1229, 350);
        drain();

        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/vcs_pkg.sv
hw/rtl/vcs_ram.sv
hw/rtl/vcs_div.sv
hw/rtl/velocity_command_smoother.sv
hw/rtl/vcs_checker.sv
tb/velocity_command_smoother_tb.sv
